/* rtl/pcgp_pkg.sv */
package pcgp_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned HALF_W   = 32;
    localparam int unsigned PROBE_W  = 32;
    localparam int unsigned LOG2_W   = 6;
    localparam logic [LOG2_W-1:0] MAX_LOG2   = 6'd32;
    localparam logic [LOG2_W-1:0] LOG2_RESET = 6'd6;

    localparam logic [WORD_W-1:0] LCG_MULT = 64'd6364136223846793005;
    localparam logic [HALF_W-1:0] MULT_LO  = LCG_MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0] MULT_HI  = LCG_MULT[WORD_W-1:HALF_W];

    // permutation shift amounts
    localparam int unsigned XSH_A = 18;
    localparam int unsigned XSH_B = 27;
    localparam int unsigned ROT_POS = 59;

    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LL,
        ST_MUL_HL,
        ST_MUL_LH,
        ST_ADD,
        ST_DELIVER
    } seq_state_t;

endpackage

/* rtl/pcgp_permute.sv */
module pcgp_permute
    import pcgp_pkg::*;
(
    input  logic [WORD_W-1:0] lcg_state,
    input  logic [LOG2_W-1:0] table_size_log2,
    output logic [PROBE_W-1:0] probe_index
);

    logic [WORD_W-1:0]  x;
    logic [4:0]         rot_r;
    logic [4:0]         rot_l;
    logic [WORD_W-1:0]  mixed;
    logic [PROBE_W-1:0] mask;

    assign x     = ((lcg_state >> XSH_A) ^ lcg_state) >> XSH_B;
    assign rot_r = lcg_state[WORD_W-1:ROT_POS];
    // (32 - r) mod 32
    assign rot_l = 5'd0 - rot_r;
    assign mixed = (x >> rot_r) | (x << rot_l);

    // exponents of 32 and above keep every bit
    assign mask = (table_size_log2 >= MAX_LOG2) ? {PROBE_W{1'b1}}
                                                : ~({PROBE_W{1'b1}} << table_size_log2[4:0]);

    assign probe_index = mixed[PROBE_W-1:0] & mask;

endmodule

/* rtl/pcg_probe_sequence_generator.sv */
// PCG-driven probe sequence generator for a power-of-two open-addressing table.
//
// Input stream (s_axis_*): one transfer per request. tuser carries op
// (0 = seed from key and emit first probe, 1 = emit next probe), tdata the
// 64-bit key (ignored for op 1). Output stream (m_axis_*): exactly one
// transfer per request, tdata = 32-bit probe index.
// cfg_wr_en/cfg_wr_data write table_size_log2 (reset 6); write only when idle.
//
// Each LCG step runs through one shared 32x32 multiplier in ST_MUL_LL,
// ST_MUL_HL and ST_MUL_LH (lo*lo, hi*lo, lo*hi partial products); ST_ADD
// then adds the increment. A next request runs one LCG step from accept to
// result register, a start request two LCG steps. s_axis_tready is high only
// while the sequencer is idle, so one request is in flight at a time and a
// new request is taken only after the previous probe reaches the output register.
//
// The result sits in an output register; if the receiver stalls, the
// sequencer holds the finished probe until the register frees up.
// Reset (rst_n low, asynchronous) returns state to 0, increment to 1,
// table_size_log2 to 6 and drops m_axis_tvalid.
module pcg_probe_sequence_generator
    import pcgp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_wr_en,
    input  logic [LOG2_W-1:0]  cfg_wr_data,    // [5:0] table_size_log2

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [WORD_W-1:0]  s_axis_tdata,   // [63:0] key
    input  logic [0:0]         s_axis_tuser,   // [0] op

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [PROBE_W-1:0] m_axis_tdata    // [31:0] probe_index
);

    seq_state_t         st_reg, st_next;
    logic               last_reg, last_next;
    logic [LOG2_W-1:0]  log2_reg;
    logic [WORD_W-1:0]  state_reg, state_next;
    logic [WORD_W-1:0]  inc_reg, inc_next;
    logic [WORD_W-1:0]  acc_reg, acc_next;
    logic [PROBE_W-1:0] probe_reg, probe_next;
    logic               m_valid_reg, m_valid_next;
    logic [PROBE_W-1:0] m_data_reg, m_data_next;

    logic               in_xfer;
    logic               out_free;
    logic [HALF_W-1:0]  mul_a, mul_b;
    logic [WORD_W-1:0]  mul_p;
    logic [WORD_W-1:0]  seed_inc;
    logic [WORD_W-1:0]  table_size;
    logic [PROBE_W-1:0] perm_out;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    assign seed_inc   = {s_axis_tdata[WORD_W-2:0], 1'b1};
    assign table_size = (log2_reg >= MAX_LOG2) ? (64'd1 << MAX_LOG2)
                                               : (64'd1 << log2_reg);

    pcgp_permute u_permute (
        .lcg_state       (state_reg),
        .table_size_log2 (log2_reg),
        .probe_index     (perm_out)
    );

    // shared multiplier
    always_comb
    begin
        unique case (st_reg)
            ST_MUL_HL:
            begin
                mul_a = state_reg[WORD_W-1:HALF_W];
                mul_b = MULT_LO;
            end
            ST_MUL_LH:
            begin
                mul_a = state_reg[HALF_W-1:0];
                mul_b = MULT_HI;
            end
            default:
            begin
                mul_a = state_reg[HALF_W-1:0];
                mul_b = MULT_LO;
            end
        endcase
    end

    assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:    if (in_xfer) st_next = ST_MUL_LL;
            ST_MUL_LL:  st_next = ST_MUL_HL;
            ST_MUL_HL:  st_next = ST_MUL_LH;
            ST_MUL_LH:  st_next = ST_ADD;
            ST_ADD:     st_next = last_reg ? ST_DELIVER : ST_MUL_LL;
            ST_DELIVER: if (out_free) st_next = ST_IDLE;
            default:    st_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        last_next    = last_reg;
        state_next   = state_reg;
        inc_next     = inc_reg;
        acc_next     = acc_reg;
        probe_next   = probe_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser[0] == OP_START)
                    begin
                        // stepping from state 0 gives the increment itself
                        inc_next   = seed_inc;
                        state_next = seed_inc + table_size;
                        last_next  = 1'b0;
                    end
                    else
                    begin
                        last_next = 1'b1;
                    end
                end
            end
            ST_MUL_LL:
            begin
                acc_next = mul_p;
                if (last_reg)
                    probe_next = perm_out;
            end
            ST_MUL_HL, ST_MUL_LH:
            begin
                acc_next[WORD_W-1:HALF_W] = acc_reg[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0];
            end
            ST_ADD:
            begin
                state_next = acc_reg + inc_reg;
                last_next  = 1'b1;
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = probe_reg;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            last_reg    <= 1'b0;
            log2_reg    <= LOG2_RESET;
            state_reg   <= '0;
            inc_reg     <= 64'd1;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            last_reg    <= last_next;
            state_reg   <= state_next;
            inc_reg     <= inc_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
                log2_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        probe_reg  <= probe_next;
        m_data_reg <= m_data_next;
    end

    assign s_axis_tready = (st_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input accepted while previous request in flight");

    a_start_two_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_axis_tuser[0] == OP_START) |=> !last_reg)
        else $error("start request must run a seeding step first");

    a_next_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_axis_tuser[0] == OP_NEXT) |=> last_reg)
        else $error("next request must run a single step");

    a_deliver_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DELIVER && out_free) |=> (m_axis_tvalid && st_reg == ST_IDLE))
        else $error("finished probe not presented");

endmodule

/* sim/tb_pcg_probe_sequence_generator.sv */
module tb_pcg_probe_sequence_generator;
    import pcgp_pkg::*;

    typedef struct {
        logic              op;
        logic [WORD_W-1:0] key;
    } probe_req_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [LOG2_W-1:0]   cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [WORD_W-1:0]   s_axis_tdata = '0;
    logic [0:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [PROBE_W-1:0]  m_axis_tdata;

    // predictor copy of the generator
    logic [WORD_W-1:0]   gen_state = '0;
    logic [WORD_W-1:0]   gen_incr = 64'd1;
    logic [LOG2_W-1:0]   table_log2 = LOG2_RESET;

    probe_req_t          pending_reqs[$];
    logic [PROBE_W-1:0]  expected_probes[$];
    probe_req_t          cur_req;
    logic [PROBE_W-1:0]  want_probe;
    bit                  req_taken = 1'b0;
    int                  idle_pct = 32;
    int                  rx_hold_left = 0;
    bit                  rx_hold_request = 1'b0;
    int                  error_count = 0;

    pcg_probe_sequence_generator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // xsh-rr style mix on the full 64-bit word
    function automatic logic [WORD_W-1:0] xsh_rr_mix(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] x;
        logic [4:0]        rot;
        logic [4:0]        lsh;
        x   = ((s >> XSH_A) ^ s) >> XSH_B;
        rot = s[WORD_W-1:ROT_POS];
        lsh = 5'd0 - rot;
        return (x >> rot) | (x << lsh);
    endfunction

    function automatic logic [WORD_W-1:0] lcg_advance();
        logic [WORD_W-1:0] mixed;
        mixed     = xsh_rr_mix(gen_state);
        gen_state = gen_state * LCG_MULT + gen_incr;
        return mixed;
    endfunction

    function automatic logic [PROBE_W-1:0] predict_probe(input logic op,
                                                         input logic [WORD_W-1:0] key);
        logic [LOG2_W-1:0] eff_log2;
        logic [WORD_W-1:0] tbl_size;
        logic [WORD_W-1:0] mixed;
        eff_log2 = (table_log2 > MAX_LOG2) ? MAX_LOG2 : table_log2;
        tbl_size = 64'd1 << eff_log2;
        if (op == OP_START)
        begin
            gen_incr  = {key[WORD_W-2:0], 1'b1};
            gen_state = '0;
            void'(lcg_advance());
            gen_state = gen_state + tbl_size;
            void'(lcg_advance());
        end
        mixed = lcg_advance();
        return mixed[PROBE_W-1:0] & tbl_size[PROBE_W-1:0] - 32'd1 | 32'd0
            ? (mixed[PROBE_W-1:0] & (tbl_size[PROBE_W-1:0] - 32'd1)) : 32'd0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void push_req(input logic op, input logic [WORD_W-1:0] key);
        probe_req_t r;
        r.op  = op;
        r.key = key;
        pending_reqs.push_back(r);
    endfunction

    function automatic logic [WORD_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // wait until no request is queued, offered or awaiting its probe
    task automatic wait_drained();
        @(posedge clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_probes.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_table_log2(input logic [LOG2_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        table_log2   = value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // sender: a new transfer is offered only once the previous one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || req_taken))
        begin
            req_taken = 1'b0;
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                cur_req = pending_reqs.pop_front();
                s_axis_tuser  <= cur_req.op;
                s_axis_tdata  <= cur_req.key;
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_probes.push_back(predict_probe(s_axis_tuser[0], s_axis_tdata));
            req_taken = 1'b1;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
            rx_hold_left = rx_hold_left - 1;
        else if (rx_hold_request)
        begin
            rx_hold_left    = 300;
            rx_hold_request = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_probes.size() == 0)
                report_mismatch($sformatf("probe %h with no request pending", m_axis_tdata));
            else
            begin
                want_probe = expected_probes.pop_front();
                if (m_axis_tdata !== want_probe)
                    report_mismatch($sformatf("probe_index %h, want %h",
                                              m_axis_tdata, want_probe));
            end
        end
    end

    initial
    begin
        int                n_seq;
        logic [LOG2_W-1:0] log2_pick;
        logic [LOG2_W-1:0] phase_log2[7];

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset exponent, next before any start runs from reset state
        push_req(OP_NEXT, rand_key());
        push_req(OP_NEXT, rand_key());
        push_req(OP_START, 64'd0);
        push_req(OP_NEXT, rand_key());
        push_req(OP_START, {WORD_W{1'b1}});
        push_req(OP_NEXT, 64'd0);
        push_req(OP_START, 64'h8000_0000_0000_0000);
        push_req(OP_START, 64'h5555_5555_5555_5555);
        push_req(OP_START, 64'hAAAA_AAAA_AAAA_AAAA);
        push_req(OP_NEXT, rand_key());

        // zero exponent: single-slot table
        write_table_log2(6'd0);
        push_req(OP_START, rand_key());
        push_req(OP_NEXT, rand_key());
        push_req(OP_NEXT, rand_key());

        write_table_log2(6'd32);
        push_req(OP_START, rand_key());
        push_req(OP_NEXT, rand_key());
        push_req(OP_NEXT, rand_key());

        // exponents above 32 clamp to 32
        write_table_log2(6'd63);
        push_req(OP_START, rand_key());
        push_req(OP_NEXT, rand_key());
        push_req(OP_NEXT, rand_key());

        write_table_log2(6'd33);
        push_req(OP_START, rand_key());
        push_req(OP_NEXT, rand_key());

        phase_log2[0] = 6'd1;
        phase_log2[1] = 6'd31;
        phase_log2[2] = 6'(($urandom_range(1, 31)));
        phase_log2[3] = 6'd32;
        phase_log2[4] = 6'd0;
        phase_log2[5] = 6'(($urandom_range(33, 63)));
        phase_log2[6] = 6'(($urandom_range(0, 63)));

        for (int ph = 0; ph < 7; ph++)
        begin
            log2_pick = phase_log2[ph];
            write_table_log2(log2_pick);
            idle_pct = (ph == 2) ? 0 : 32;
            n_seq = 0;
            while (n_seq < 100)
            begin
                if ($urandom_range(9) == 0)
                begin
                    push_req(logic'($urandom_range(1)), rand_key());
                    n_seq++;
                end
                else
                begin
                    push_req(OP_START, rand_key());
                    n_seq++;
                    repeat ($urandom_range(7))
                    begin
                        push_req(OP_NEXT, rand_key());
                        n_seq++;
                    end
                end
            end
            if (ph == 3)
                rx_hold_request = 1'b1;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
